// ===== hw/rtl/hsv2rgb_pkg.sv =====
// Constants, sector codes and divide-by-255 helpers for the HSV to RGB converter.
package hsv2rgb_pkg;

	localparam logic [7:0]  UNIT      = 8'd255;
	localparam logic [16:0] FRAC_ONE  = 17'h10000;
	localparam logic [23:0] DEN       = 24'd16711680;
	localparam logic [15:0] ROUND_P   = 16'd127;

	localparam logic [2:0] SECTOR_RED_YELLOW    = 3'd0;
	localparam logic [2:0] SECTOR_YELLOW_GREEN  = 3'd1;
	localparam logic [2:0] SECTOR_GREEN_CYAN    = 3'd2;
	localparam logic [2:0] SECTOR_CYAN_BLUE     = 3'd3;
	localparam logic [2:0] SECTOR_BLUE_MAGENTA  = 3'd4;
	localparam logic [2:0] SECTOR_MAGENTA_RED   = 3'd5;

	// The estimate x*257/65536 is never above x/255 and at most one below it.
	function automatic logic [7:0] div255_est(input logic [15:0] x);
		logic [24:0] prod;
		prod = {9'd0, x} * 25'd257;
		return prod[23:16];
	endfunction

	function automatic logic [15:0] rem255(input logic [15:0] x, input logic [7:0] qe);
		logic [15:0] m;
		m = {8'd0, qe} * 16'd255;
		return x - m;
	endfunction

	function automatic logic [7:0] div255_fix(input logic [15:0] x, input logic [7:0] qe);
		logic [15:0] r;
		r = rem255(x, qe);
		return (r >= 16'd255) ? qe + 8'd1 : qe;
	endfunction

endpackage

// ===== hw/rtl/hsv_to_rgb_converter_top.sv =====
// HSV to RGB converter: five-stage pipeline, one pixel in and one pixel out per request.
// An accepted input request is registered through stages one to five to a valid output.
// One pixel per cycle while out_ready is high; each stage holds while the next one stalls.
// The unsigned multipliers and the divide-by-255 units in stages one to five set the depth.
// Reset clears every stage valid bit at once; the data registers are not reset.
module hsv_to_rgb_converter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] hue,
	input  logic [7:0]  saturation,
	input  logic [7:0]  brightness,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);
	import hsv2rgb_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	logic [2:0]  sector_s1, sector_s2, sector_s3, sector_s4;
	logic [15:0] f_s1;
	logic [7:0]  s_s1;
	logic [7:0]  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [15:0] pm_s1;
	logic [23:0] aq_s2, at_s2;
	logic [15:0] xp_s2, xp_s3, xp_s4;
	logic [31:0] nq_s3, nt_s3;
	logic [15:0] xq_s4, xt_s4;
	logic [7:0]  eq_s4, et_s4, ep_s4;
	logic [7:0]  red_s5, green_s5, blue_s5;

	logic [18:0] h6;
	logic [23:0] sf;
	logic [16:0] fc;
	logic [24:0] sfc;
	logic [24:0] at_full;
	logic [33:0] sum_q, sum_t;
	logic [15:0] xq, xt;
	logic [7:0]  pv, qv, tv;

	assign adv5 = !valid_s5 || out_ready;
	assign adv4 = !valid_s4 || adv5;
	assign adv3 = !valid_s3 || adv4;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv5) valid_s5 <= valid_s4;
		end
	end

	assign h6 = {3'd0, hue} * 19'd6;

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			sector_s1 <= h6[18:16];
			f_s1      <= h6[15:0];
			s_s1      <= saturation;
			v_s1      <= brightness;
			pm_s1     <= {8'd0, brightness} * {8'd0, UNIT - saturation};
		end
	end

	assign sf      = {16'd0, s_s1} * {8'd0, f_s1};
	assign fc      = FRAC_ONE - {1'b0, f_s1};
	assign sfc     = {17'd0, s_s1} * {8'd0, fc};
	assign at_full = {1'b0, DEN} - sfc;

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			sector_s2 <= sector_s1;
			v_s2      <= v_s1;
			aq_s2     <= DEN - sf;
			at_s2     <= at_full[23:0];
			xp_s2     <= pm_s1 + ROUND_P;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			sector_s3 <= sector_s2;
			v_s3      <= v_s2;
			xp_s3     <= xp_s2;
			nq_s3     <= {24'd0, v_s2} * {8'd0, aq_s2};
			nt_s3     <= {24'd0, v_s2} * {8'd0, at_s2};
		end
	end

	// Rounding half up: floor((2n + D) / (255 * 2^17)) = floor(((2n + D) >> 17) / 255).
	assign sum_q = {1'b0, nq_s3, 1'b0} + {10'd0, DEN};
	assign sum_t = {1'b0, nt_s3, 1'b0} + {10'd0, DEN};
	assign xq    = sum_q[32:17];
	assign xt    = sum_t[32:17];

	always_ff @(posedge clk) begin
		if (adv4 && valid_s3) begin
			sector_s4 <= sector_s3;
			v_s4      <= v_s3;
			xq_s4     <= xq;
			xt_s4     <= xt;
			xp_s4     <= xp_s3;
			eq_s4     <= div255_est(xq);
			et_s4     <= div255_est(xt);
			ep_s4     <= div255_est(xp_s3);
		end
	end

	assign qv = div255_fix(xq_s4, eq_s4);
	assign tv = div255_fix(xt_s4, et_s4);
	assign pv = div255_fix(xp_s4, ep_s4);

	// Zero saturation makes p, q and t equal to v, so grey needs no special path.
	always_ff @(posedge clk) begin
		if (adv5 && valid_s4) begin
			v_s5 <= v_s4;
			case (sector_s4)
				SECTOR_RED_YELLOW: begin
					red_s5 <= v_s4; green_s5 <= tv; blue_s5 <= pv;
				end
				SECTOR_YELLOW_GREEN: begin
					red_s5 <= qv; green_s5 <= v_s4; blue_s5 <= pv;
				end
				SECTOR_GREEN_CYAN: begin
					red_s5 <= pv; green_s5 <= v_s4; blue_s5 <= tv;
				end
				SECTOR_CYAN_BLUE: begin
					red_s5 <= pv; green_s5 <= qv; blue_s5 <= v_s4;
				end
				SECTOR_BLUE_MAGENTA: begin
					red_s5 <= tv; green_s5 <= pv; blue_s5 <= v_s4;
				end
				default: begin
					red_s5 <= v_s4; green_s5 <= pv; blue_s5 <= qv;
				end
			endcase
		end
	end

	assign out_valid = valid_s5;
	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5))
		else $error("input stalled while the pipeline has a bubble");

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (sector_s1 <= SECTOR_MAGENTA_RED))
		else $error("hue sector out of range");

	a_estimate_close: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (rem255(xq_s4, eq_s4) < 16'd510 && rem255(xt_s4, et_s4) < 16'd510
			&& rem255(xp_s4, ep_s4) < 16'd510))
		else $error("divide-by-255 estimate off by more than one");

	a_channels_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> (red_s5 <= v_s5 && green_s5 <= v_s5 && blue_s5 <= v_s5
			&& (red_s5 == v_s5 || green_s5 == v_s5 || blue_s5 == v_s5)))
		else $error("output channel does not match the brightness bound");

endmodule

// ===== verif/tb_hsv_to_rgb_converter_top.sv =====
// Self-checking HSV to RGB converter testbench: pixel scoreboard, directed and random traffic.
module tb_hsv_to_rgb_converter_top;
	import hsv2rgb_pkg::*;

	localparam int RANDOM_PIXELS = 1150;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 20;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	class pixel_scoreboard;
		rgb_t expected_rgb[$];
		int mismatches = 0;
		int checked = 0;
		int grey_pixels = 0;
		bit [5:0] sectors_seen = '0;

		function automatic logic [7:0] round_ratio(longint unsigned num, longint unsigned den);
			return 8'((2 * num + den) / (2 * den));
		endfunction

		function rgb_t hsv_to_rgb(logic [15:0] h, logic [7:0] s, logic [7:0] v);
			logic [18:0] h6;
			logic [2:0] sector;
			longint unsigned frac, full, num_p, num_q, num_t;
			logic [7:0] p, q, t;
			rgb_t c;
			if (s == 8'd0) begin
				c = '{v, v, v};
				grey_pixels++;
				return c;
			end
			h6 = 19'(h) * 19'd6;
			sector = h6[18:16];
			frac = longint'(h6[15:0]);
			full = 64'd255 * 64'd65536;
			num_p = longint'(v) * (64'd255 - longint'(s));
			num_q = longint'(v) * (full - longint'(s) * frac);
			num_t = longint'(v) * (full - longint'(s) * (64'd65536 - frac));
			p = round_ratio(num_p, 64'd255);
			q = round_ratio(num_q, full);
			t = round_ratio(num_t, full);
			sectors_seen[sector] = 1'b1;
			case (sector)
				SECTOR_RED_YELLOW: c = '{v, t, p};
				SECTOR_YELLOW_GREEN: c = '{q, v, p};
				SECTOR_GREEN_CYAN: c = '{p, v, t};
				SECTOR_CYAN_BLUE: c = '{p, q, v};
				SECTOR_BLUE_MAGENTA: c = '{t, p, v};
				default: c = '{v, p, q};
			endcase
			return c;
		endfunction

		function void note_request(logic [15:0] h, logic [7:0] s, logic [7:0] v);
			expected_rgb.push_back(hsv_to_rgb(h, s, v));
		endfunction

		function int pending();
			return expected_rgb.size();
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			rgb_t want;
			if (expected_rgb.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel (%0d,%0d,%0d)", r, g, b));
				return;
			end
			want = expected_rgb.pop_front();
			checked++;
			if (r !== want.red)
				report_mismatch($sformatf("red got %0d expected %0d", r, want.red));
			if (g !== want.green)
				report_mismatch($sformatf("green got %0d expected %0d", g, want.green));
			if (b !== want.blue)
				report_mismatch($sformatf("blue got %0d expected %0d", b, want.blue));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [15:0] hue;
	logic [7:0] saturation;
	logic [7:0] brightness;
	logic out_valid;
	logic out_ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	pixel_scoreboard sb = new();
	int sent_count = 0;
	int idle_count = 0;
	int stall_cycle = 0;
	int stall_mode = 0;

	hsv_to_rgb_converter_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.hue(hue),
		.saturation(saturation),
		.brightness(brightness),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red(red),
		.green(green),
		.blue(blue)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic send_pixel(logic [15:0] h, logic [7:0] s, logic [7:0] v);
		@(negedge clk);
		in_valid = 1'b1;
		hue = h;
		saturation = s;
		brightness = v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(h, s, v);
		sent_count++;
	endtask

	task automatic hold_off(int n);
		repeat (n) begin
			@(negedge clk);
			in_valid = 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(1, 3));
			3: return 8'($urandom_range(252, 254));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [15:0] pick_hue();
		int b;
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(0, 1) ? 65535 : 0);
			1, 2: begin
				b = int'($urandom_range(0, 6)) * 10923 + int'($urandom_range(0, 6)) - 3;
				if (b < 0)
					b = 0;
				if (b > 65535)
					b = 65535;
				return 16'(b);
			end
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	always @(negedge clk) begin
		stall_cycle++;
		if (stall_cycle % 256 == 0)
			stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: out_ready = 1'b1;
			1: out_ready = ($urandom_range(0, 3) != 0);
			default: out_ready = (stall_cycle % 7) < 4;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(red, green, blue);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_count = 0;
		else
			idle_count++;
		if (idle_count >= WATCHDOG_LIMIT) begin
			$display("Timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int burst;
		int random_sent;
		arst_n = 1'b0;
		in_valid = 1'b0;
		hue = '0;
		saturation = '0;
		brightness = '0;
		out_ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_pixel(16'd0, 8'd255, 8'd255);
		send_pixel(16'd65535, 8'd255, 8'd255);
		send_pixel(16'd12345, 8'd0, 8'd200);
		send_pixel(16'd40000, 8'd0, 8'd255);
		send_pixel(16'd65535, 8'd0, 8'd0);
		send_pixel(16'd30000, 8'd255, 8'd0);
		send_pixel(16'd10922, 8'd255, 8'd255);
		send_pixel(16'd10923, 8'd255, 8'd255);
		send_pixel(16'd21845, 8'd200, 8'd180);
		send_pixel(16'd21846, 8'd200, 8'd180);
		send_pixel(16'd32767, 8'd128, 8'd255);
		send_pixel(16'd32768, 8'd128, 8'd255);
		send_pixel(16'd43690, 8'd1, 8'd255);
		send_pixel(16'd43691, 8'd1, 8'd255);
		send_pixel(16'd54613, 8'd254, 8'd1);
		send_pixel(16'd54614, 8'd254, 8'd1);
		send_pixel(16'd60000, 8'd77, 8'd133);
		send_pixel(16'd5461, 8'd170, 8'd85);
		send_pixel(16'd16384, 8'd255, 8'd128);
		send_pixel(16'd49152, 8'd127, 8'd127);
		send_pixel(16'hAAAA, 8'h55, 8'hAA);
		send_pixel(16'h5555, 8'hAA, 8'h55);
		wait_drained();

		random_sent = 0;
		while (random_sent < RANDOM_PIXELS) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && random_sent < RANDOM_PIXELS; i++) begin
				send_pixel(pick_hue(), pick_byte(), pick_byte());
				random_sent++;
			end
			if (random_sent >= RANDOM_PIXELS / 2 && random_sent - burst < RANDOM_PIXELS / 2)
				wait_drained();
			else if ($urandom_range(0, 2) != 0)
				hold_off($urandom_range(1, 6));
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d pixels (%0d grey), sector mask %b, %0d results checked.",
			sent_count, sb.grey_pixels, sb.sectors_seen, sb.checked);
		$display("Mismatches: %0d, results still outstanding: %0d.", sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
